[hdl/buddy_page_allocator_macros.svh]
// ----------------------------------------------------------------------------
// buddy_page_allocator_macros
// Assertion macros used by the buddy page allocator RTL
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge outside reset
`define BPA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define BPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BPA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[hdl/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Constants and types shared by the buddy page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

    // pool geometry
    localparam int ORDER_COUNT = 8;
    localparam int POOL_PAGES  = 1024;
    localparam int PAGE_SHIFT  = 12;

    localparam int TOP_ORDER = ORDER_COUNT - 1;
    localparam int TOP_PAGES = 1 << TOP_ORDER;
    localparam int TOP_SHIFT = TOP_ORDER + PAGE_SHIFT;
    localparam longint unsigned TOP_BYTES = 64'd1 << TOP_SHIFT;

    // field widths
    localparam int TYPE_W  = 2;
    localparam int BYTES_W = 23;
    localparam int PAGE_W  = $clog2(POOL_PAGES);
    localparam int NUM_W   = PAGE_W + 1;
    localparam int ORD_W   = (ORDER_COUNT > 2) ? $clog2(ORDER_COUNT) : 1;

    // free mark memory: one row holds ROW_BITS pages of one order
    localparam int ROW_BITS     = 32;
    localparam int ROW_W        = $clog2(ROW_BITS);
    localparam int ROWS_PER_ORD = POOL_PAGES / ROW_BITS;
    localparam int RPO_W        = PAGE_W - ROW_W;
    localparam int MARK_DEPTH   = ORDER_COUNT * ROWS_PER_ORD;
    localparam int MARK_AW      = ORD_W + RPO_W;

    // top order block indexing and multi-block runs
    localparam int TOP_COUNT = POOL_PAGES / TOP_PAGES;
    localparam int TOP_W     = PAGE_W - TOP_ORDER;
    localparam int RUN_W     = (BYTES_W + 1 > TOP_SHIFT) ? (BYTES_W + 1 - TOP_SHIFT) : 1;
    localparam int TIDX_W    = ((TOP_W + 1 > RUN_W) ? (TOP_W + 1) : RUN_W) + 1;

    // request codes
    localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_INIT  = 2'd2;

    typedef struct packed {
        logic               we;
        logic [MARK_AW-1:0] addr;
        logic [ROW_BITS-1:0] wdata;
    } t_mark_cmd;

    typedef struct packed {
        logic               we;
        logic [PAGE_W-1:0]  addr;
        logic [BYTES_W-1:0] wdata;
    } t_size_cmd;

    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] granted_page;
        logic              success;
    } t_result;

endpackage

[hdl/bpa_req_if.sv]
// ----------------------------------------------------------------------------
// bpa_req_if
// Request channel of the buddy page allocator
// ----------------------------------------------------------------------------
interface bpa_req_if;
    import bpa_pkg::*;

    logic               valid;
    logic               ready;
    logic [TYPE_W-1:0]  req_type;
    logic [BYTES_W-1:0] request_bytes;
    logic [PAGE_W-1:0]  page_index;

    modport source (output valid, output req_type, output request_bytes,
                    output page_index, input ready);
    modport sink (input valid, input req_type, input request_bytes,
                  input page_index, output ready);
endinterface

[hdl/bpa_rsp_if.sv]
// ----------------------------------------------------------------------------
// bpa_rsp_if
// Response channel of the buddy page allocator
// ----------------------------------------------------------------------------
interface bpa_rsp_if;
    import bpa_pkg::*;

    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] granted_page;
    logic              success;

    modport source (output valid, output granted_page, output success, input ready);
    modport sink (input valid, input granted_page, input success, output ready);
endinterface

[hdl/buddy_page_allocator.sv]
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator over a page pool, free marks and sizes kept in RAM
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  i_req    in   valid/ready      req_type, request_bytes, page_index
//  o_rsp    out  valid/ready      granted_page, success
//  i_cfg    in   i_cfg_we only    i_cfg_wdata = region_pages
//
//  one item at a time through a sequencer around one mark RAM port:
//  allocate scans mark rows (up to 32 per order) from the wanted order up,
//  then splits level by level; multi-block allocate checks top blocks, then
//  clears each block taken; free merges level by level; init rewrites every row.
//  after reset a clearing pass over every mark row runs before the first item is taken.
//  a new item is taken while a result waits in the output register.
module buddy_page_allocator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    bpa_req_if.sink                   i_req,
    bpa_rsp_if.source                 o_rsp,
    input  logic                      i_cfg_we,
    input  logic [bpa_pkg::NUM_W-1:0] i_cfg_wdata
);
    import bpa_pkg::*;

    logic [NUM_W-1:0]    r_region;
    logic                r_out_valid;
    logic [PAGE_W-1:0]   r_out_page;
    logic                r_out_ok;
    t_mark_cmd           mark_cmd;
    t_size_cmd           size_cmd;
    t_result             res;
    logic [ROW_BITS-1:0] mark_rdata;
    logic [BYTES_W-1:0]  size_rdata;
    logic                res_ready;

    assign res_ready = !r_out_valid || o_rsp.ready;

    bpa_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .i_region_pages (r_region),
        .o_mark         (mark_cmd),
        .i_mark_rdata   (mark_rdata),
        .o_size         (size_cmd),
        .i_size_rdata   (size_rdata),
        .o_res          (res),
        .i_res_ready    (res_ready)
    );

    // free marks, one row per order and page group
    bpa_ram #(.WIDTH(ROW_BITS), .DEPTH(MARK_DEPTH)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_cmd.we),
        .i_addr  (mark_cmd.addr),
        .i_wdata (mark_cmd.wdata),
        .o_rdata (mark_rdata)
    );

    // byte size per start page
    bpa_ram #(.WIDTH(BYTES_W), .DEPTH(POOL_PAGES)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (size_cmd.we),
        .i_addr  (size_cmd.addr),
        .i_wdata (size_cmd.wdata),
        .o_rdata (size_rdata)
    );

    // region register and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region    <= NUM_W'(1024);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_region <= i_cfg_wdata;
            end
            if (res.valid && res_ready) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) begin
            r_out_page <= res.granted_page;
            r_out_ok   <= res.success;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.granted_page = r_out_page;
    assign o_rsp.success      = r_out_ok;
endmodule

[hdl/bpa_ram.sv]
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single port RAM with registered read data
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read, old data on collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/bpa_ctrl.sv]
// ----------------------------------------------------------------------------
// bpa_ctrl
// Request sequencer: scans, splits and merges free marks held in memory
// ----------------------------------------------------------------------------
`include "buddy_page_allocator_macros.svh"

module bpa_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bpa_req_if.sink                      i_req,
    input  logic [bpa_pkg::NUM_W-1:0]    i_region_pages,
    output bpa_pkg::t_mark_cmd           o_mark,
    input  logic [bpa_pkg::ROW_BITS-1:0] i_mark_rdata,
    output bpa_pkg::t_size_cmd           o_size,
    input  logic [bpa_pkg::BYTES_W-1:0]  i_size_rdata,
    output bpa_pkg::t_result             o_res,
    input  logic                         i_res_ready
);
    import bpa_pkg::*;

    localparam logic [4:0] S_IDLE       = 5'd0;
    localparam logic [4:0] S_SWEEP      = 5'd1;
    localparam logic [4:0] S_SCAN       = 5'd2;
    localparam logic [4:0] S_SPLIT_RD   = 5'd3;
    localparam logic [4:0] S_SPLIT_WR   = 5'd4;
    localparam logic [4:0] S_ALLOC_DONE = 5'd5;
    localparam logic [4:0] S_RUN_RD     = 5'd6;
    localparam logic [4:0] S_RUN_CK     = 5'd7;
    localparam logic [4:0] S_RUN_CLR_RD = 5'd8;
    localparam logic [4:0] S_RUN_CLR_WR = 5'd9;
    localparam logic [4:0] S_FREE_SZ    = 5'd10;
    localparam logic [4:0] S_MRG_RD     = 5'd11;
    localparam logic [4:0] S_MRG_CK     = 5'd12;
    localparam logic [4:0] S_MRG_CP_RD  = 5'd13;
    localparam logic [4:0] S_MRG_CP_WR  = 5'd14;
    localparam logic [4:0] S_MRG_SET_RD = 5'd15;
    localparam logic [4:0] S_MRG_SET_WR = 5'd16;
    localparam logic [4:0] S_BFREE_RD   = 5'd17;
    localparam logic [4:0] S_BFREE_WR   = 5'd18;
    localparam logic [4:0] S_FIN        = 5'd19;

    localparam logic [MARK_AW-1:0] LAST_ROW = MARK_AW'(MARK_DEPTH - 1);
    localparam logic [ORD_W-1:0]   TOP_ORD  = ORD_W'(TOP_ORDER);

    // smallest order whose block holds the byte count
    function automatic logic [ORD_W-1:0] order_for(input logic [BYTES_W-1:0] bytes);
        logic [ORD_W-1:0] k;
        k = TOP_ORD;
        for (int kk = TOP_ORDER - 1; kk >= 0; kk--) begin
            if (64'(bytes) <= (64'd1 << (kk + PAGE_SHIFT))) begin
                k = ORD_W'(kk);
            end
        end
        return k;
    endfunction

    // number of top blocks for a byte count
    function automatic logic [RUN_W-1:0] run_len(input logic [BYTES_W-1:0] bytes);
        logic [63:0] n;
        n = (64'(bytes) + TOP_BYTES - 64'd1) >> TOP_SHIFT;
        return RUN_W'(n);
    endfunction

    function automatic logic [MARK_AW-1:0] mark_addr(input logic [ORD_W-1:0] ord,
                                                     input logic [PAGE_W-1:0] page);
        return {ord, page[PAGE_W-1:ROW_W]};
    endfunction

    function automatic logic [ROW_BITS-1:0] mark_bit(input logic [PAGE_W-1:0] page);
        return ROW_BITS'(1) << page[ROW_W-1:0];
    endfunction

    // lowest set bit of a row
    function automatic logic [ROW_W-1:0] lowest_bit(input logic [ROW_BITS-1:0] v);
        logic [ROW_W-1:0] idx;
        idx = '0;
        for (int b = ROW_BITS - 1; b >= 0; b--) begin
            if (v[b]) begin
                idx = ROW_W'(b);
            end
        end
        return idx;
    endfunction

    // row contents after carving n pages into largest aligned blocks
    function automatic logic [ROW_BITS-1:0] init_row(input logic [MARK_AW-1:0] addr,
                                                     input logic [NUM_W-1:0] n);
        logic [ROW_BITS-1:0] row;
        logic [ORD_W-1:0]    ord;
        logic [PAGE_W-1:0]   page;
        logic [NUM_W-1:0]    keep;
        ord  = addr[MARK_AW-1:RPO_W];
        keep = ~((NUM_W'(2) << ord) - NUM_W'(1));
        for (int b = 0; b < ROW_BITS; b++) begin
            page = {addr[RPO_W-1:0], ROW_W'(b)};
            if (ord == TOP_ORD) begin
                row[b] = (page[TOP_ORDER-1:0] == '0)
                      && ({1'b0, page} + NUM_W'(TOP_PAGES) <= n);
            end else begin
                row[b] = n[ord] && ({1'b0, page} == (n & keep));
            end
        end
        return row;
    endfunction

    logic [4:0]          r_state, n_state;
    logic [MARK_AW-1:0]  r_sweep, n_sweep;
    logic                r_from_rst, n_from_rst;
    logic [NUM_W-1:0]    r_init_n, n_init_n;
    logic [MARK_AW-1:0]  r_iss, n_iss;
    logic [MARK_AW-1:0]  r_chk_addr, n_chk_addr;
    logic                r_chk_v, n_chk_v;
    logic [ORD_W-1:0]    r_korder, n_korder;
    logic [BYTES_W-1:0]  r_bytes, n_bytes;
    logic [PAGE_W-1:0]   r_page, n_page;
    logic [ORD_W-1:0]    r_mord, n_mord;
    logic [PAGE_W-1:0]   r_mpage, n_mpage;
    logic [RUN_W-1:0]    r_need, n_need;
    logic [TIDX_W-1:0]   r_cand, n_cand;
    logic [RUN_W-1:0]    r_i, n_i;
    logic [PAGE_W-1:0]   r_res_page, n_res_page;
    logic                r_res_ok, n_res_ok;

    logic                req_fire;
    logic [TIDX_W-1:0]   top_idx;
    logic                top_in_pool;
    logic [PAGE_W-1:0]   top_page;
    logic [PAGE_W-1:0]   buddy;
    logic [PAGE_W-1:0]   split_page;
    logic [ORD_W-1:0]    split_ord;
    logic [ORD_W-1:0]    found_ord;
    logic [PAGE_W-1:0]   found_page;
    logic [NUM_W-1:0]    region_clamped;

    assign req_fire       = i_req.valid && i_req.ready;
    assign i_req.ready    = (r_state == S_IDLE);
    assign top_idx        = r_cand + TIDX_W'(r_i);
    assign top_in_pool    = (top_idx < TIDX_W'(TOP_COUNT));
    assign top_page       = PAGE_W'(top_idx[TOP_W-1:0]) << TOP_ORDER;
    assign buddy          = r_mpage ^ (PAGE_W'(1) << r_mord);
    assign split_ord      = r_mord - ORD_W'(1);
    assign split_page     = r_page | (PAGE_W'(1) << split_ord);
    assign found_ord      = r_chk_addr[MARK_AW-1:RPO_W];
    assign found_page     = {r_chk_addr[RPO_W-1:0], lowest_bit(i_mark_rdata)};
    assign region_clamped = (i_region_pages > NUM_W'(POOL_PAGES))
                          ? NUM_W'(POOL_PAGES) : i_region_pages;

    assign o_res.valid        = (r_state == S_FIN);
    assign o_res.granted_page = r_res_page;
    assign o_res.success      = r_res_ok;

    // next state and memory commands
    always_comb begin
        n_state    = r_state;
        n_sweep    = r_sweep;
        n_from_rst = r_from_rst;
        n_init_n   = r_init_n;
        n_iss      = r_iss;
        n_chk_addr = r_chk_addr;
        n_chk_v    = r_chk_v;
        n_korder   = r_korder;
        n_bytes    = r_bytes;
        n_page     = r_page;
        n_mord     = r_mord;
        n_mpage    = r_mpage;
        n_need     = r_need;
        n_cand     = r_cand;
        n_i        = r_i;
        n_res_page = r_res_page;
        n_res_ok   = r_res_ok;
        o_mark.we    = 1'b0;
        o_mark.addr  = mark_addr(r_mord, r_mpage);
        o_mark.wdata = i_mark_rdata;
        o_size.we    = 1'b0;
        o_size.addr  = i_req.page_index;
        o_size.wdata = r_bytes;

        case (r_state)
            // take a request
            S_IDLE: begin
                if (req_fire) begin
                    n_res_page = '0;
                    n_res_ok   = 1'b1;
                    case (i_req.req_type)
                        REQ_ALLOC: begin
                            n_bytes = i_req.request_bytes;
                            if (64'(i_req.request_bytes) <= TOP_BYTES) begin
                                n_korder = order_for(i_req.request_bytes);
                                n_iss    = {order_for(i_req.request_bytes), RPO_W'(0)};
                                n_chk_v  = 1'b0;
                                n_state  = S_SCAN;
                            end else begin
                                n_need  = run_len(i_req.request_bytes);
                                n_cand  = '0;
                                n_i     = '0;
                                n_state = S_RUN_RD;
                            end
                        end
                        REQ_FREE: begin
                            n_page  = i_req.page_index;
                            n_state = S_FREE_SZ;
                        end
                        REQ_INIT: begin
                            n_init_n   = region_clamped;
                            n_sweep    = '0;
                            n_from_rst = 1'b0;
                            n_state    = S_SWEEP;
                        end
                        default: begin
                            n_res_ok = 1'b0;
                            n_state  = S_FIN;
                        end
                    endcase
                end
            end

            // rewrite every mark row
            S_SWEEP: begin
                o_mark.we    = 1'b1;
                o_mark.addr  = r_sweep;
                o_mark.wdata = init_row(r_sweep, r_init_n);
                n_sweep      = r_sweep + MARK_AW'(1);
                if (r_sweep == LAST_ROW) begin
                    n_state = r_from_rst ? S_IDLE : S_FIN;
                end
            end

            // pipelined row scan from the wanted order upward
            S_SCAN: begin
                o_mark.addr = r_iss;
                n_chk_addr  = r_iss;
                n_chk_v     = 1'b1;
                if (r_iss != LAST_ROW) begin
                    n_iss = r_iss + MARK_AW'(1);
                end
                if (r_chk_v && (i_mark_rdata != '0)) begin
                    o_mark.we    = 1'b1;
                    o_mark.addr  = r_chk_addr;
                    o_mark.wdata = i_mark_rdata & ~mark_bit(found_page);
                    n_page       = found_page;
                    n_mord       = found_ord;
                    n_state      = (found_ord > r_korder) ? S_SPLIT_RD : S_ALLOC_DONE;
                end else if (r_chk_v && (r_chk_addr == LAST_ROW)) begin
                    n_res_ok = 1'b0;
                    n_state  = S_FIN;
                end
            end

            // hand the upper half to the next lower order
            S_SPLIT_RD: begin
                o_mark.addr = mark_addr(split_ord, split_page);
                n_mord      = split_ord;
                n_mpage     = split_page;
                n_state     = S_SPLIT_WR;
            end
            S_SPLIT_WR: begin
                o_mark.we    = 1'b1;
                o_mark.wdata = i_mark_rdata | mark_bit(r_mpage);
                n_state      = (r_mord > r_korder) ? S_SPLIT_RD : S_ALLOC_DONE;
            end

            // record the size at the start page
            S_ALLOC_DONE: begin
                o_size.we    = 1'b1;
                o_size.addr  = r_page;
                n_res_page   = r_page;
                n_state      = S_FIN;
            end

            // look for a run of free top blocks
            S_RUN_RD: begin
                o_mark.addr = mark_addr(TOP_ORD, top_page);
                if (top_in_pool) begin
                    n_state = S_RUN_CK;
                end else begin
                    n_res_ok = 1'b0;
                    n_state  = S_FIN;
                end
            end
            S_RUN_CK: begin
                if ((i_mark_rdata & mark_bit(top_page)) != '0) begin
                    if (r_i == r_need - RUN_W'(1)) begin
                        n_i     = '0;
                        n_state = S_RUN_CLR_RD;
                    end else begin
                        n_i     = r_i + RUN_W'(1);
                        n_state = S_RUN_RD;
                    end
                end else begin
                    n_cand  = r_cand + TIDX_W'(1);
                    n_i     = '0;
                    n_state = S_RUN_RD;
                end
            end
            S_RUN_CLR_RD: begin
                o_mark.addr = mark_addr(TOP_ORD, top_page);
                n_state     = S_RUN_CLR_WR;
            end
            S_RUN_CLR_WR: begin
                o_mark.we    = 1'b1;
                o_mark.addr  = mark_addr(TOP_ORD, top_page);
                o_mark.wdata = i_mark_rdata & ~mark_bit(top_page);
                n_i          = r_i + RUN_W'(1);
                if (r_i == r_need - RUN_W'(1)) begin
                    n_page  = PAGE_W'(r_cand[TOP_W-1:0]) << TOP_ORDER;
                    n_state = S_ALLOC_DONE;
                end else begin
                    n_state = S_RUN_CLR_RD;
                end
            end

            // recorded size tells the order of the freed block
            S_FREE_SZ: begin
                if (64'(i_size_rdata) <= TOP_BYTES) begin
                    n_mord  = order_for(i_size_rdata);
                    n_mpage = r_page & ~((PAGE_W'(1) << order_for(i_size_rdata))
                                         - PAGE_W'(1));
                    n_state = S_MRG_RD;
                end else begin
                    n_need  = run_len(i_size_rdata);
                    n_cand  = TIDX_W'(r_page[PAGE_W-1:TOP_ORDER]);
                    n_i     = '0;
                    n_state = S_BFREE_RD;
                end
            end

            // merge with a free buddy while one exists
            S_MRG_RD: begin
                o_mark.addr = mark_addr(r_mord, buddy);
                n_state     = (r_mord == TOP_ORD) ? S_MRG_SET_RD : S_MRG_CK;
            end
            S_MRG_CK: begin
                o_mark.addr = mark_addr(r_mord, buddy);
                if ((i_mark_rdata & mark_bit(buddy)) != '0) begin
                    o_mark.we    = 1'b1;
                    o_mark.wdata = i_mark_rdata & ~mark_bit(buddy);
                    n_state      = S_MRG_CP_RD;
                end else begin
                    n_state = S_MRG_SET_RD;
                end
            end
            S_MRG_CP_RD: begin
                n_state = S_MRG_CP_WR;
            end
            S_MRG_CP_WR: begin
                o_mark.we    = 1'b1;
                o_mark.wdata = i_mark_rdata & ~mark_bit(r_mpage);
                n_mpage      = r_mpage & ~(PAGE_W'(1) << r_mord);
                n_mord       = r_mord + ORD_W'(1);
                n_state      = S_MRG_RD;
            end
            S_MRG_SET_RD: begin
                n_state = S_MRG_SET_WR;
            end
            S_MRG_SET_WR: begin
                o_mark.we    = 1'b1;
                o_mark.wdata = i_mark_rdata | mark_bit(r_mpage);
                n_state      = S_FIN;
            end

            // return a multi-block run
            S_BFREE_RD: begin
                o_mark.addr = mark_addr(TOP_ORD, top_page);
                if ((r_i == r_need) || !top_in_pool) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_BFREE_WR;
                end
            end
            S_BFREE_WR: begin
                o_mark.we    = 1'b1;
                o_mark.addr  = mark_addr(TOP_ORD, top_page);
                o_mark.wdata = i_mark_rdata | mark_bit(top_page);
                n_i          = r_i + RUN_W'(1);
                n_state      = S_BFREE_RD;
            end

            // hold the result until the output stage takes it
            S_FIN: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers, reset starts a clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_SWEEP;
            r_sweep    <= '0;
            r_from_rst <= 1'b1;
            r_init_n   <= '0;
            r_chk_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sweep    <= n_sweep;
            r_from_rst <= n_from_rst;
            r_init_n   <= n_init_n;
            r_chk_v    <= n_chk_v;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_iss      <= n_iss;
        r_chk_addr <= n_chk_addr;
        r_korder   <= n_korder;
        r_bytes    <= n_bytes;
        r_page     <= n_page;
        r_mord     <= n_mord;
        r_mpage    <= n_mpage;
        r_need     <= n_need;
        r_cand     <= n_cand;
        r_i        <= n_i;
        r_res_page <= n_res_page;
        r_res_ok   <= n_res_ok;
    end

    `BPA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, req_fire, r_state != S_IDLE, "request accepted but sequencer stayed idle")
    `BPA_ASSERT(a_no_write_when_idle, i_clk, i_rst_n, !(o_mark.we && (r_state == S_IDLE)), "mark write while idle")
    `BPA_ASSERT(a_split_above_target, i_clk, i_rst_n, !((r_state == S_SPLIT_RD) && (r_mord <= r_korder)), "split below wanted order")
    `BPA_ASSERT(a_size_write_on_grant, i_clk, i_rst_n, !(o_size.we && (r_state != S_ALLOC_DONE)), "size written outside a grant")
endmodule

[test/bpa_alloc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_alloc_checker
// Watches the request, response and region write ports of the buddy page
// allocator, keeps its own copy of the free marks and recorded sizes, works
// out the grant for every accepted request and compares responses in order
// ----------------------------------------------------------------------------
module bpa_alloc_checker
    import bpa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    bpa_req_if               i_req,
    bpa_rsp_if               i_rsp,
    input  logic             i_cfg_we,
    input  logic [NUM_W-1:0] i_cfg_wdata,
    output int               o_errors,
    output int               o_pending
);

    typedef struct {
        logic [PAGE_W-1:0] page;
        logic              ok;
    } t_grant;

    bit                 free_map [ORDER_COUNT][POOL_PAGES];
    logic [BYTES_W-1:0] size_at [POOL_PAGES];
    logic [NUM_W-1:0]   region;
    t_grant             grants_due [$];

    assign o_pending = grants_due.size();

    // one line per mismatch
    task automatic report(input string what, input int got, input int want);
        $display("error at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_errors = o_errors + 1;
    endtask

    function automatic int lowest_free(input int k);
        for (int p = 0; p < POOL_PAGES; p++)
            if (free_map[k][p]) return p;
        return -1;
    endfunction

    function automatic int order_of(input longint unsigned sz);
        int k;
        for (k = 0; k < TOP_ORDER; k++)
            if (sz <= (64'd1 << (k + PAGE_SHIFT))) break;
        return k;
    endfunction

    function automatic void carve_region();
        int n;
        int p;
        int k;
        n = (region > POOL_PAGES) ? POOL_PAGES : region;
        p = 0;
        foreach (free_map[i, j]) free_map[i][j] = 0;
        while (p < n) begin
            k = TOP_ORDER;
            while (k > 0 && (((p & ((1 << k) - 1)) != 0) || (1 << k) > n - p)) k--;
            free_map[k][p] = 1;
            p += 1 << k;
        end
    endfunction

    // lowest block of order k, splitting a larger one if needed
    function automatic int take_block(input int k);
        int j;
        int p;
        p = -1;
        for (j = k; j < ORDER_COUNT; j++) begin
            p = lowest_free(j);
            if (p >= 0) break;
        end
        if (p < 0) return -1;
        free_map[j][p] = 0;
        while (j > k) begin
            j--;
            free_map[j][p + (1 << j)] = 1;
        end
        return p;
    endfunction

    // lowest run of contiguous free top blocks
    function automatic int take_run(input longint unsigned cnt);
        bit ok;
        longint unsigned q;
        for (int s = 0; s < POOL_PAGES; s++) begin
            ok = 1;
            for (longint unsigned i = 0; i < cnt; i++) begin
                q = s + i * TOP_PAGES;
                if (q >= POOL_PAGES || !free_map[TOP_ORDER][q]) begin
                    ok = 0;
                    break;
                end
            end
            if (ok) begin
                for (longint unsigned i = 0; i < cnt; i++)
                    free_map[TOP_ORDER][s + i * TOP_PAGES] = 0;
                return s;
            end
        end
        return -1;
    endfunction

    function automatic void give_back(input int page);
        longint unsigned sz;
        longint unsigned cnt;
        int k;
        int p;
        int b;
        int base;
        sz = size_at[page];
        if (sz <= TOP_BYTES) begin
            k = order_of(sz);
            p = page & ~((1 << k) - 1);
            while (k < TOP_ORDER) begin
                b = p ^ (1 << k);
                if (b >= POOL_PAGES || !free_map[k][b]) break;
                free_map[k][b] = 0;
                free_map[k][p] = 0;
                p &= ~(1 << k);
                k++;
            end
            free_map[k][p] = 1;
        end else begin
            cnt = (sz + TOP_BYTES - 1) / TOP_BYTES;
            base = page & ~(TOP_PAGES - 1);
            for (longint unsigned i = 0; i < cnt; i++) begin
                if (base + i * TOP_PAGES >= POOL_PAGES) break;
                free_map[TOP_ORDER][base + i * TOP_PAGES] = 1;
            end
        end
    endfunction

    function automatic t_grant serve(input logic [TYPE_W-1:0] kind,
                                     input logic [BYTES_W-1:0] bytes,
                                     input logic [PAGE_W-1:0] page);
        t_grant g;
        int got;
        g.page = '0;
        g.ok = 1'b0;
        case (kind)
            REQ_ALLOC: begin
                if (bytes <= TOP_BYTES) got = take_block(order_of(bytes));
                else got = take_run((64'(bytes) + TOP_BYTES - 1) / TOP_BYTES);
                if (got >= 0) begin
                    size_at[got] = bytes;
                    g.page = PAGE_W'(got);
                    g.ok = 1'b1;
                end
            end
            REQ_FREE: begin
                if (page < POOL_PAGES) give_back(page);
                g.ok = 1'b1;
            end
            REQ_INIT: begin
                carve_region();
                g.ok = 1'b1;
            end
            default: ;
        endcase
        return g;
    endfunction

    initial o_errors = 0;

    // predict on each accepted request, compare on each accepted response
    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            foreach (free_map[i, j]) free_map[i][j] = 0;
            region = NUM_W'(1024);
            grants_due.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (grants_due.size() == 0) begin
                    report("unexpected response, granted_page", i_rsp.granted_page, -1);
                end else begin
                    want = grants_due.pop_front();
                    if (i_rsp.granted_page !== want.page)
                        report("granted_page", i_rsp.granted_page, want.page);
                    if (i_rsp.success !== want.ok)
                        report("success", i_rsp.success, want.ok);
                end
            end
            if (i_req.valid && i_req.ready)
                grants_due.push_back(serve(i_req.req_type, i_req.request_bytes,
                                           i_req.page_index));
            if (i_cfg_we) region = i_cfg_wdata;
        end
    end

endmodule

[test/tb_buddy_page_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buddy_page_allocator
// Drives allocate, free and init requests into the buddy page allocator over
// several region sizes, with random gaps and response stalls, and lets the
// checker beside it judge every response
// ----------------------------------------------------------------------------
module tb_buddy_page_allocator;
    import bpa_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [TYPE_W-1:0] REQ_RESERVED = 2'd3;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [NUM_W-1:0] cfg_wdata;
    int               errors;
    int               pending;
    int               cycles;
    bit               calm;

    bpa_req_if req_ch ();
    bpa_rsp_if rsp_ch ();

    buddy_page_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch.sink),
        .o_rsp       (rsp_ch.source),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    bpa_alloc_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // page bookkeeping for legal frees
    logic [TYPE_W-1:0] sent_kinds [$];
    int                live_pages [$];
    int                sized_pages [$];
    bit                sized [POOL_PAGES];

    // clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // response stalls in bursts
    int stall_left;
    int run_left;
    always @(posedge i_clk) begin
        if (calm) begin
            rsp_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end else if (run_left > 0) begin
            run_left <= run_left - 1;
            rsp_ch.ready <= 1'b1;
        end else begin
            stall_left <= $urandom_range(0, 3) == 0 ? $urandom_range(1, 18) : 0;
            run_left <= $urandom_range(1, 40);
            rsp_ch.ready <= 1'b1;
        end
    end

    // learn granted pages from responses
    always @(posedge i_clk) begin
        logic [TYPE_W-1:0] k;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready && sent_kinds.size() > 0) begin
            k = sent_kinds.pop_front();
            if (k == REQ_ALLOC && rsp_ch.success) begin
                live_pages.push_back(rsp_ch.granted_page);
                if (!sized[rsp_ch.granted_page]) sized_pages.push_back(rsp_ch.granted_page);
                sized[rsp_ch.granted_page] = 1;
            end
        end
    end

    // one request, held until accepted, then an optional gap
    task automatic send(input logic [TYPE_W-1:0] kind, input logic [BYTES_W-1:0] bytes,
                        input logic [PAGE_W-1:0] page);
        int gap;
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.request_bytes <= bytes;
        req_ch.page_index <= page;
        do @(posedge i_clk); while (!req_ch.ready);
        sent_kinds.push_back(kind);
        gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_region(input int pages);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= NUM_W'(pages);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [BYTES_W-1:0] pick_bytes();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return BYTES_W'($urandom_range(0, 8192));
        if (r < 75) return BYTES_W'($urandom_range(0, 65536));
        if (r < 90) return BYTES_W'($urandom_range(0, 524288));
        if (r < 97) return BYTES_W'($urandom_range(524289, 2097152));
        return BYTES_W'($urandom_range(0, 4194304));
    endfunction

    task automatic free_live(input int at);
        int p;
        p = live_pages[at];
        live_pages.delete(at);
        send(REQ_FREE, BYTES_W'($urandom_range(0, 8388607)), PAGE_W'(p));
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 38 && live_pages.size() > 0)
            free_live($urandom_range(0, live_pages.size() - 1));
        else if (r < 41 && sized_pages.size() > 0)
            send(REQ_FREE, BYTES_W'($urandom),
                 PAGE_W'(sized_pages[$urandom_range(0, sized_pages.size() - 1)]));
        else if (r < 44)
            send(REQ_RESERVED, BYTES_W'($urandom), PAGE_W'($urandom));
        else if (r < 46) begin
            send(REQ_INIT, BYTES_W'($urandom), PAGE_W'($urandom));
            live_pages.delete();
        end else
            send(REQ_ALLOC, pick_bytes(), PAGE_W'($urandom));
    endtask

    int regions [8] = '{2047, 1024, 0, 1, 200, 1000, 1023, 77};

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        calm = 1'b0;
        cycles = 0;
        stall_left = 0;
        run_left = 0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_ALLOC;
        req_ch.request_bytes = '0;
        req_ch.page_index = '0;
        rsp_ch.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty pool, reserved type, edge sizes, frees, full pool run
        send(REQ_ALLOC, 100, 0);
        send(REQ_RESERVED, 8388607, 1023);
        send(REQ_INIT, 0, 0);
        send(REQ_ALLOC, 0, 1023);
        send(REQ_ALLOC, 1, 0);
        send(REQ_ALLOC, 4096, 0);
        send(REQ_ALLOC, 4097, 0);
        send(REQ_ALLOC, 524288, 0);
        send(REQ_ALLOC, 524289, 0);
        send(REQ_ALLOC, 4194304, 0);
        drain();
        send(REQ_FREE, 0, PAGE_W'(sized_pages[0]));
        while (live_pages.size() > 0) free_live(0);
        send(REQ_FREE, 0, PAGE_W'(sized_pages[1]));
        send(REQ_INIT, 0, 0);
        send(REQ_ALLOC, 4194304, 0);
        drain();
        free_live(0);
        send(REQ_ALLOC, 8191, 0);
        drain();

        // random phases over region sizes
        foreach (regions[i]) begin
            set_region(regions[i]);
            live_pages.delete();
            send(REQ_INIT, BYTES_W'($urandom), PAGE_W'($urandom));
            if (i == 7) calm = 1'b1;
            for (int n = 0; n < 78; n++) begin
                random_item();
                if ($urandom_range(0, 49) == 0) drain();
            end
        end

        drain();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/bpa_pkg.sv
hdl/bpa_req_if.sv
hdl/bpa_rsp_if.sv
hdl/bpa_ram.sv
hdl/bpa_ctrl.sv
hdl/buddy_page_allocator.sv
test/bpa_alloc_checker.sv
test/tb_buddy_page_allocator.sv
